// ===== rtl/rtt_pkg.sv =====
package rtt_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_BITS = 4;
  localparam int TIME_BITS = 32;
  localparam int CNT_BITS  = 16;
  localparam int TAG_BITS  = 16;

  localparam logic [3:0] FN_ADD        = 4'd0;
  localparam logic [3:0] FN_TICK       = 4'd1;
  localparam logic [3:0] FN_START_ID   = 4'd2;
  localparam logic [3:0] FN_STOP_ID    = 4'd3;
  localparam logic [3:0] FN_REMOVE_ID  = 4'd4;
  localparam logic [3:0] FN_START_ALL  = 4'd5;
  localparam logic [3:0] FN_STOP_ALL   = 4'd6;
  localparam logic [3:0] FN_REMOVE_ALL = 4'd7;
  localparam logic [3:0] FN_START_NM   = 4'd8;
  localparam logic [3:0] FN_STOP_NM    = 4'd9;
  localparam logic [3:0] FN_REMOVE_NM  = 4'd10;
  localparam logic [3:0] FN_BIND       = 4'd11;
  localparam logic [3:0] FN_REMOVE_OWN = 4'd12;
  localparam logic [3:0] FN_RESET_TIME = 4'd13;

  localparam logic [2:0] KD_ADDED = 3'd0;
  localparam logic [2:0] KD_DONE  = 3'd1;
  localparam logic [2:0] KD_FIRED = 3'd2;
  localparam logic [2:0] KD_FULL  = 3'd3;
  localparam logic [2:0] KD_NOID  = 3'd4;

  typedef struct packed {
    logic [3:0]           func;
    logic [SLOT_BITS-1:0] timer_id;
    logic [TIME_BITS-1:0] interval;
    logic [CNT_BITS-1:0]  repeat_count;
    logic [TAG_BITS-1:0]  name_tag;
    logic [TAG_BITS-1:0]  owner_tag;
    logic [TIME_BITS-1:0] now;
    logic                 paused;
  } cmd_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [SLOT_BITS-1:0] slot;
    logic                 last;
  } res_t;

endpackage

// ===== rtl/rtt_front.sv =====
module rtt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  rtt_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_ready,
  output rtt_pkg::cmd_t q_cmd
);
  import rtt_pkg::*;

  // Two-entry queue decouples acceptance from the slot engine.
  cmd_t q0_r, q1_r, q0_nxt, q1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign in_tready = (cnt_r != 2'd2);
  assign push = in_tvalid && in_tready;
  assign pop = q_valid && q_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = q0_r;

  always_comb begin
    q0_nxt = q0_r;
    q1_nxt = q1_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      q0_nxt = q1_r;
      cnt_nxt = cnt_nxt - 2'd1;
    end
    if (push) begin
      if (cnt_nxt == 2'd0) begin
        q0_nxt = in_cmd;
      end else begin
        q1_nxt = in_cmd;
      end
      cnt_nxt = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 && !pop |=> cnt_r == 2'd2)
    else $error("full queue changed without pop");
  a_valid_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid == (cnt_r != 2'd0))
    else $error("queue valid mismatch");
`endif
endmodule

// ===== rtl/rtt_back.sv =====
module rtt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  rtt_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output rtt_pkg::res_t out_res
);
  import rtt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [NUM_SLOTS-1:0] used_r, used_nxt, run_r, run_nxt, rem_r, rem_nxt;
  logic [CNT_BITS-1:0]  cnt_r [NUM_SLOTS];
  logic [CNT_BITS-1:0]  lim_r [NUM_SLOTS];
  logic [TIME_BITS-1:0] per_r [NUM_SLOTS];
  logic [TIME_BITS-1:0] lst_r [NUM_SLOTS];
  logic [TAG_BITS-1:0]  nam_r [NUM_SLOTS];
  logic [TAG_BITS-1:0]  own_r [NUM_SLOTS];

  logic [1:0]           st_r, st_nxt;
  logic [SLOT_BITS-1:0] idx_r, idx_nxt;
  cmd_t                 cur_r, cur_nxt;
  logic                 ov_r, ov_nxt;
  res_t                 or_r, or_nxt;

  logic                 take, obusy;
  logic                 has_free;
  logic [SLOT_BITS-1:0] free_idx;
  logic                 id_ok;
  logic [TIME_BITS-1:0] elapsed;
  logic [CNT_BITS-1:0]  cnt_inc;
  logic                 fire;

  assign out_valid = ov_r;
  assign out_res = or_r;
  assign obusy = ov_r && !out_ready;
  assign q_ready = (st_r == ST_IDLE) && !obusy;
  assign take = q_valid && q_ready;

  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        has_free = 1'b1;
        free_idx = SLOT_BITS'(i);
      end
    end
  end

  assign id_ok = used_r[q_cmd.timer_id];
  assign elapsed = cur_r.now - lst_r[idx_r];
  assign cnt_inc = cnt_r[idx_r] + 1'b1;
  assign fire = used_r[idx_r] && !rem_r[idx_r] && run_r[idx_r] &&
                (per_r[idx_r] == '0 || elapsed >= per_r[idx_r]);

  always_comb begin
    used_nxt = used_r;
    run_nxt = run_r;
    rem_nxt = rem_r;
    st_nxt = st_r;
    idx_nxt = idx_r;
    cur_nxt = cur_r;
    ov_nxt = ov_r && !out_ready;
    or_nxt = or_r;
    if (take) begin
      cur_nxt = q_cmd;
      idx_nxt = '0;
      ov_nxt = 1'b1;
      or_nxt = '{kind: KD_DONE, slot: '0, last: 1'b1};
      case (q_cmd.func)
        FN_ADD: begin
          if (has_free) begin
            used_nxt[free_idx] = 1'b1;
            run_nxt[free_idx] = 1'b1;
            rem_nxt[free_idx] = 1'b0;
            or_nxt = '{kind: KD_ADDED, slot: free_idx, last: 1'b1};
          end else begin
            or_nxt.kind = KD_FULL;
          end
        end
        FN_START_ID, FN_STOP_ID, FN_REMOVE_ID, FN_BIND: begin
          or_nxt.slot = q_cmd.timer_id;
          if (!id_ok) begin
            or_nxt.kind = KD_NOID;
          end else if (q_cmd.func == FN_START_ID) begin
            run_nxt[q_cmd.timer_id] = 1'b1;
          end else if (q_cmd.func == FN_STOP_ID) begin
            run_nxt[q_cmd.timer_id] = 1'b0;
          end else if (q_cmd.func == FN_REMOVE_ID) begin
            rem_nxt[q_cmd.timer_id] = 1'b1;
          end
        end
        FN_TICK: begin
          if (!q_cmd.paused) begin
            ov_nxt = ov_r && !out_ready;
            st_nxt = ST_SCAN;
          end
        end
        FN_START_ALL, FN_STOP_ALL, FN_REMOVE_ALL, FN_START_NM, FN_STOP_NM,
        FN_REMOVE_NM, FN_REMOVE_OWN, FN_RESET_TIME: begin
          ov_nxt = ov_r && !out_ready;
          st_nxt = ST_SCAN;
        end
        default: ;
      endcase
    end else if (st_r == ST_SCAN && !obusy) begin
      // Unless stalled, one slot per cycle; fired results are registered.
      if (used_r[idx_r]) begin
        case (cur_r.func)
          FN_TICK: begin
            if (rem_r[idx_r]) begin
              used_nxt[idx_r] = 1'b0;
              run_nxt[idx_r] = 1'b0;
              rem_nxt[idx_r] = 1'b0;
            end else if (fire) begin
              if (lim_r[idx_r] != '0 && cnt_inc == lim_r[idx_r]) begin
                rem_nxt[idx_r] = 1'b1;
              end
              ov_nxt = 1'b1;
              or_nxt = '{kind: KD_FIRED, slot: idx_r, last: 1'b0};
            end
          end
          FN_START_ALL: run_nxt[idx_r] = 1'b1;
          FN_STOP_ALL: run_nxt[idx_r] = 1'b0;
          FN_REMOVE_ALL: rem_nxt[idx_r] = 1'b1;
          FN_START_NM: if (nam_r[idx_r] == cur_r.name_tag) run_nxt[idx_r] = 1'b1;
          FN_STOP_NM: if (nam_r[idx_r] == cur_r.name_tag) run_nxt[idx_r] = 1'b0;
          FN_REMOVE_NM: if (nam_r[idx_r] == cur_r.name_tag) rem_nxt[idx_r] = 1'b1;
          FN_REMOVE_OWN: if (own_r[idx_r] == cur_r.owner_tag) rem_nxt[idx_r] = 1'b1;
          default: ;
        endcase
      end
      idx_nxt = idx_r + 1'b1;
      if (idx_r == SLOT_BITS'(NUM_SLOTS - 1)) begin
        st_nxt = ST_DONE;
      end
    end else if (st_r == ST_DONE && !obusy) begin
      ov_nxt = 1'b1;
      or_nxt = '{kind: KD_DONE, slot: '0, last: 1'b1};
      st_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    or_r <= or_nxt;
    idx_r <= idx_nxt;
    if (take && q_cmd.func == FN_ADD && has_free) begin
      cnt_r[free_idx] <= '0;
      lim_r[free_idx] <= q_cmd.repeat_count;
      per_r[free_idx] <= q_cmd.interval;
      lst_r[free_idx] <= q_cmd.now;
      nam_r[free_idx] <= q_cmd.name_tag;
      own_r[free_idx] <= '0;
    end
    if (take && q_cmd.func == FN_BIND && id_ok) begin
      own_r[q_cmd.timer_id] <= q_cmd.owner_tag;
    end
    if (st_r == ST_SCAN && !obusy && used_r[idx_r]) begin
      if (cur_r.func == FN_TICK && fire) begin
        cnt_r[idx_r] <= cnt_inc;
        lst_r[idx_r] <= lst_r[idx_r] + per_r[idx_r];
      end
      if (cur_r.func == FN_RESET_TIME) begin
        lst_r[idx_r] <= cur_r.now;
      end
    end
    if (!rst_n) begin
      used_r <= '0;
      run_r <= '0;
      rem_r <= '0;
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        cnt_r[i] <= '0;
        own_r[i] <= '0;
      end
    end else begin
      used_r <= used_nxt;
      run_r <= run_nxt;
      rem_r <= rem_nxt;
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("result changed while stalled");
  a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.kind == KD_FIRED |-> !out_res.last)
    else $error("fired result marked last");
  a_no_take_scan: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> !q_ready)
    else $error("command taken during scan");
  a_removed_used: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r & ~used_r) == '0)
    else $error("removed flag on free slot");
`endif
endmodule

// ===== rtl/repeating_timer_table_top.sv =====
// channel | dir | tdata fields (low bit up)                          | tuser
// in_     | in  | timer_id, interval, repeat_count, name_tag,         | func
//         |     | owner_tag, now, paused (117 bits, zero-padded to 120)|
// out_    | out | slot (4 bits, zero-padded to 8)                     | kind; tlast = last
// Add, id, paused tick and unused commands occupy the slot engine only at take and give
// their result through the queue register and then the result register. A tick or a
// scan command holds it through take, a walk over every slot and the closing result.
// A two-entry command queue keeps accepting while the engine works, until it is full.
// Reset (rst_n low, synchronous) frees every slot and empties the queue.
// A stalled result register halts the slot walk for as long as it waits.
module repeating_timer_table_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,  // timer_id, interval, repeat_count, name_tag, owner_tag, now, paused
  input  logic [3:0]   in_tuser,  // func
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata, // slot
  output logic [2:0]   out_tuser, // kind
  output logic         out_tlast
);
  import rtt_pkg::*;

  cmd_t in_cmd, q_cmd;
  res_t res;
  logic q_valid, q_ready;

  assign in_cmd.func = in_tuser;
  assign in_cmd.timer_id = in_tdata[3:0];
  assign in_cmd.interval = in_tdata[35:4];
  assign in_cmd.repeat_count = in_tdata[51:36];
  assign in_cmd.name_tag = in_tdata[67:52];
  assign in_cmd.owner_tag = in_tdata[83:68];
  assign in_cmd.now = in_tdata[115:84];
  assign in_cmd.paused = in_tdata[116];

  rtt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  rtt_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {4'd0, res.slot};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;
endmodule
